/* sv/ncpe_pkg.sv */
// ============================================================================
// ncpe_pkg
// Shared types, codes and fixed-point helpers for the NURBS curve point
// evaluator.
// ============================================================================
package ncpe_pkg;

    // field and datapath widths
    localparam int KNOT_W  = 25;
    localparam int COORD_W = 32;
    localparam int WGT_W   = 24;
    localparam int NB_W    = 32;   // basis value, Q30 signed
    localparam int DIFF_W  = 26;   // knot difference, Q24 signed
    localparam int DEN_W   = 27;   // sum of two differences
    localparam int OPA_W   = 34;
    localparam int OPB_W   = 33;
    localparam int PROD_W  = 67;
    localparam int BW_W    = 34;   // weighted basis, Q24 signed
    localparam int ACC_W   = 64;
    localparam int BW_SHIFT = 22;

    // request operations
    localparam logic [1:0] OP_WKNOT = 2'd0;
    localparam logic [1:0] OP_WPT   = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_WZERO = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic CFG_DEGREE = 1'b0;
    localparam logic CFG_LAST   = 1'b1;

    localparam logic signed [NB_W-1:0]  BASIS_ONE  = 32'sh4000_0000;
    localparam logic signed [ACC_W-1:0] ONE_64     = 64'sd1073741824;
    localparam logic signed [ACC_W-1:0] INT64_MAXV = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] INT64_MINV = 64'sh8000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] I32_MAX64  = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] I32_MIN64  = -64'sd2147483648;

    // datapath micro-operations
    typedef enum logic [4:0] {
        DP_NOP, DP_WKNOT, DP_WPT, DP_LOAD, DP_LFT, DP_RGT, DP_NB0, DP_TERM,
        DP_MUL_A, DP_MUL_B, DP_DIV_GO, DP_SAVE_A, DP_UPD, DP_UPD_Z, DP_NBJ,
        DP_BW_MUL, DP_BW, DP_MC, DP_AC, DP_QOUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] sel;   // coordinate x, y, z
        logic       fin;   // divider takes the final sums
    } t_dp_cmd;

    typedef struct packed {
        logic u_lt_k;
        logic u_eq_k;
        logic den_zero;
        logic sw_zero;
        logic div_done;
    } t_dp_stat;

    // clamp to [-1.0, 1.0] in Q30
    function automatic logic signed [NB_W-1:0] clamp_basis(input logic signed [ACC_W-1:0] v);
        logic signed [NB_W-1:0] res;
        if (v > ONE_64) res = BASIS_ONE;
        else if (v < -ONE_64) res = -BASIS_ONE;
        else res = v[NB_W-1:0];
        return res;
    endfunction

    // clamp to signed 32 bit
    function automatic logic signed [COORD_W-1:0] clamp32(input logic signed [ACC_W-1:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > I32_MAX64) res = 32'sh7FFF_FFFF;
        else if (v < I32_MIN64) res = 32'sh8000_0000;
        else res = v[COORD_W-1:0];
        return res;
    endfunction

    // saturating signed 64-bit add
    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        logic signed [ACC_W-1:0] res;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) res = s[ACC_W] ? INT64_MINV : INT64_MAXV;
        else res = s[ACC_W-1:0];
        return res;
    endfunction

endpackage

/* sv/ncpe_div.sv */
// ============================================================================
// ncpe_div
// Shared radix-2 restoring divider, signed 64 / 64, truncating toward zero.
// ============================================================================
module ncpe_div
    import ncpe_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_num,
    input  logic signed [ACC_W-1:0] i_den,
    output logic signed [ACC_W-1:0] o_q,
    output logic                    o_done
);

    localparam int CW = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]        r_nmag;
    logic [ACC_W-1:0]        r_dmag;
    logic [ACC_W-1:0]        r_rem;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic                    r_neg;
    logic                    r_done;
    logic signed [ACC_W-1:0] r_q;
    logic [ACC_W:0]          w_rsh;
    logic [ACC_W:0]          w_diff;
    logic                    w_ge;

    // one quotient bit per cycle
    assign w_rsh  = {r_rem, r_nmag[ACC_W-1]};
    assign w_diff = w_rsh - {1'b0, r_dmag};
    assign w_ge   = (w_rsh >= {1'b0, r_dmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ACC_W);
                r_neg  <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
                r_nmag <= i_num[ACC_W-1] ? -i_num : i_num;
                r_dmag <= i_den[ACC_W-1] ? -i_den : i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_rem  <= w_ge ? w_diff[ACC_W-1:0] : w_rsh[ACC_W-1:0];
                    r_nmag <= {r_nmag[ACC_W-2:0], w_ge};
                    r_cnt  <= r_cnt - 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    // a positive 2^63 only arises from the most negative / -1
                    if (r_neg) r_q <= -$signed(r_nmag);
                    else if (r_nmag[ACC_W-1]) r_q <= INT64_MAXV;
                    else r_q <= $signed(r_nmag);
                end
            end
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

/* sv/ncpe_dp.sv */
// ============================================================================
// ncpe_dp
// Datapath: knot and control point memories, basis registers, one shared
// multiplier, the divider and the weighted accumulators.
// ============================================================================
module ncpe_dp
    import ncpe_pkg::*;
#(
    parameter  int MAX_DEGREE      = 7,
    parameter  int MAX_CTRL_POINTS = 32,
    parameter  int MAX_KNOTS       = 64,
    localparam int DW = $clog2(MAX_DEGREE + 1),
    localparam int KA = $clog2(MAX_KNOTS),
    localparam int PA = $clog2(MAX_CTRL_POINTS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [DW-1:0]             i_jidx,
    input  logic [DW-1:0]             i_ridx,
    input  logic [KA-1:0]             i_kaddr,
    input  logic [PA-1:0]             i_paddr,
    input  logic [5:0]                i_index,
    input  logic [KNOT_W-1:0]         i_knot_value,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic [WGT_W-1:0]          i_point_weight,
    input  logic [KNOT_W-1:0]         i_param_u,
    output t_dp_stat                  o_stat,
    output logic signed [COORD_W-1:0] o_curve_x,
    output logic signed [COORD_W-1:0] o_curve_y,
    output logic signed [COORD_W-1:0] o_curve_z
);

    // memories
    logic [KNOT_W-1:0]         r_kmem [MAX_KNOTS];
    logic signed [COORD_W-1:0] r_xmem [MAX_CTRL_POINTS];
    logic signed [COORD_W-1:0] r_ymem [MAX_CTRL_POINTS];
    logic signed [COORD_W-1:0] r_zmem [MAX_CTRL_POINTS];
    logic [WGT_W-1:0]          r_wmem [MAX_CTRL_POINTS];
    logic [KNOT_W-1:0]         r_kdata;
    logic signed [COORD_W-1:0] r_xd, r_yd, r_zd;
    logic [WGT_W-1:0]          r_wd;

    // recurrence state
    logic [KNOT_W-1:0]         r_u;
    logic signed [NB_W-1:0]    r_nb  [MAX_DEGREE + 1];
    logic signed [DIFF_W-1:0]  r_lft [MAX_DEGREE + 1];
    logic signed [DIFF_W-1:0]  r_rgt [MAX_DEGREE + 1];
    logic signed [NB_W-1:0]    r_nbv;
    logic signed [DIFF_W-1:0]  r_lv, r_rv;
    logic signed [DEN_W-1:0]   r_den;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_a, r_carry;
    logic signed [BW_W-1:0]    r_bw;
    logic signed [ACC_W-1:0]   r_sx, r_sy, r_sz, r_sw;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_cz;

    logic [DW-1:0]             w_jmr, w_rp1;
    logic signed [OPA_W-1:0]   w_opa;
    logic signed [OPB_W-1:0]   w_opb;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_bwsum;
    logic signed [BW_W-1:0]    w_bwv;
    logic signed [COORD_W-1:0] w_coord;
    logic signed [ACC_W-1:0]   w_ssel;
    logic signed [ACC_W-1:0]   w_num, w_den, w_q;
    logic                      w_div_go, w_div_done;

    assign w_jmr = i_jidx - i_ridx;
    assign w_rp1 = i_ridx + 1'b1;

    // coordinate select
    always_comb begin
        unique case (i_cmd.sel)
            2'd0:    begin w_coord = r_xd; w_ssel = r_sx; end
            2'd1:    begin w_coord = r_yd; w_ssel = r_sy; end
            default: begin w_coord = r_zd; w_ssel = r_sz; end
        endcase
    end

    // shared multiplier operands
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        unique case (i_cmd.op)
            DP_MUL_A:  begin w_opa = OPA_W'(r_nbv); w_opb = OPB_W'(r_rv); end
            DP_MUL_B:  begin w_opa = OPA_W'(r_nbv); w_opb = OPB_W'(r_lv); end
            DP_BW_MUL: begin
                w_opa = OPA_W'(r_nb[i_ridx]);
                w_opb = $signed({{(OPB_W-WGT_W){1'b0}}, r_wd});
            end
            DP_MC:     begin w_opa = OPA_W'(r_bw); w_opb = OPB_W'(w_coord); end
            default:   ;
        endcase
    end
    assign w_prod = w_opa * w_opb;

    // weighted basis, divide by 2^22 toward zero
    assign w_bwsum = r_prod + (r_prod[PROD_W-1] ? PROD_W'((1 << BW_SHIFT) - 1) : '0);
    assign w_bwv   = BW_W'(w_bwsum >>> BW_SHIFT);

    // divider operands
    assign w_num    = i_cmd.fin ? w_ssel : r_prod[ACC_W-1:0];
    assign w_den    = i_cmd.fin ? r_sw : ACC_W'(r_den);
    assign w_div_go = (i_cmd.op == DP_DIV_GO);

    ncpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_q     (w_q),
        .o_done  (w_div_done)
    );

    // memories: write on requests, registered read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_WKNOT && {26'd0, i_index} < 32'(MAX_KNOTS))
            r_kmem[KA'(i_index)] <= i_knot_value;
        if (i_cmd.op == DP_WPT && {26'd0, i_index} < 32'(MAX_CTRL_POINTS)) begin
            r_xmem[PA'(i_index)] <= i_point_x;
            r_ymem[PA'(i_index)] <= i_point_y;
            r_zmem[PA'(i_index)] <= i_point_z;
            r_wmem[PA'(i_index)] <= i_point_weight;
        end
        r_kdata <= r_kmem[i_kaddr];
        r_xd    <= r_xmem[i_paddr];
        r_yd    <= r_ymem[i_paddr];
        r_zd    <= r_zmem[i_paddr];
        r_wd    <= r_wmem[i_paddr];
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_u  <= i_param_u;
                r_sx <= '0;
                r_sy <= '0;
                r_sz <= '0;
                r_sw <= '0;
                r_cx <= '0;
                r_cy <= '0;
                r_cz <= '0;
            end
            DP_LFT: r_lft[i_jidx] <= $signed({1'b0, r_u}) - $signed({1'b0, r_kdata});
            DP_RGT: begin
                r_rgt[i_jidx] <= $signed({1'b0, r_kdata}) - $signed({1'b0, r_u});
                r_carry       <= '0;
            end
            DP_NB0: r_nb[0] <= BASIS_ONE;
            DP_TERM: begin
                r_nbv <= r_nb[i_ridx];
                r_lv  <= r_lft[w_jmr];
                r_rv  <= r_rgt[w_rp1];
                r_den <= DEN_W'(r_rgt[w_rp1]) + DEN_W'(r_lft[w_jmr]);
            end
            DP_MUL_A, DP_MUL_B, DP_BW_MUL, DP_MC: r_prod <= w_prod;
            DP_SAVE_A: r_a <= w_q;
            DP_UPD: begin
                r_nb[i_ridx] <= clamp_basis(r_carry + r_a);
                r_carry      <= w_q;
            end
            DP_UPD_Z: begin
                r_nb[i_ridx] <= clamp_basis(r_carry);
                r_carry      <= '0;
            end
            DP_NBJ: r_nb[i_jidx] <= clamp_basis(r_carry);
            DP_BW: begin
                r_bw <= w_bwv;
                r_sw <= sat_add(r_sw, ACC_W'(w_bwv));
            end
            DP_AC: begin
                unique case (i_cmd.sel)
                    2'd0:    r_sx <= sat_add(r_sx, r_prod[ACC_W-1:0]);
                    2'd1:    r_sy <= sat_add(r_sy, r_prod[ACC_W-1:0]);
                    default: r_sz <= sat_add(r_sz, r_prod[ACC_W-1:0]);
                endcase
            end
            DP_QOUT: begin
                unique case (i_cmd.sel)
                    2'd0:    r_cx <= clamp32(w_q);
                    2'd1:    r_cy <= clamp32(w_q);
                    default: r_cz <= clamp32(w_q);
                endcase
            end
            default: ;
        endcase
    end

    // status back to the controller
    assign o_stat.u_lt_k   = (r_u < r_kdata);
    assign o_stat.u_eq_k   = (r_u == r_kdata);
    assign o_stat.den_zero = (r_den == '0);
    assign o_stat.sw_zero  = (r_sw == '0);
    assign o_stat.div_done = w_div_done;

    assign o_curve_x = r_cx;
    assign o_curve_y = r_cy;
    assign o_curve_z = r_cz;

endmodule

/* sv/ncpe_ctrl.sv */
// ============================================================================
// ncpe_ctrl
// Controller: configuration registers, request decode, span search and the
// sequencing of the basis recurrence, weighted sums and final divisions.
// ============================================================================
module ncpe_ctrl
    import ncpe_pkg::*;
#(
    parameter  int MAX_DEGREE      = 7,
    parameter  int MAX_CTRL_POINTS = 32,
    parameter  int MAX_KNOTS       = 64,
    localparam int DW = $clog2(MAX_DEGREE + 1),
    localparam int KA = $clog2(MAX_KNOTS),
    localparam int PA = $clog2(MAX_CTRL_POINTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    i_operation,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_index,
    input  logic [4:0]    i_cfg_data,
    output t_dp_cmd       o_cmd,
    output logic [DW-1:0] o_jidx,
    output logic [DW-1:0] o_ridx,
    output logic [KA-1:0] o_kaddr,
    output logic [PA-1:0] o_paddr,
    input  t_dp_stat      i_stat,
    output logic          o_result_valid,
    output logic [1:0]    o_status
);

    localparam int IW = $clog2(MAX_KNOTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_END, S_LOW, S_MA, S_MB, S_MC, S_BAS, S_JL, S_JLW, S_JRW,
        S_T, S_TD, S_DA, S_WA, S_MB2, S_DB, S_WB, S_NBJ, S_KR, S_KW, S_BW,
        S_MCO, S_ACO, S_FIN, S_FD, S_FW
    } t_state;

    t_state        r_state;
    logic [2:0]    r_degree;
    logic [4:0]    r_last;
    logic [KA-1:0] r_span, r_lo, r_hi, r_mid;
    logic [DW-1:0] r_j, r_r;
    logic [1:0]    r_sel;
    logic [IW-1:0] r_iter;
    logic          r_lt, r_gtend;
    logic          r_res_valid;
    logic [1:0]    r_status;

    logic [DW-1:0] w_p;
    logic          w_bad;
    logic          w_accept;
    logic [KA-1:0] w_nlo, w_nhi, w_nmid;
    logic [KA:0]   w_lh;
    logic          w_found;

    // effective degree and setup check
    assign w_p = (32'(r_degree) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(r_degree);
    assign w_bad = (32'(r_last) < 32'(w_p)) || (32'(r_last) >= MAX_CTRL_POINTS)
                || (32'(r_last) + 32'(w_p) + 1 >= MAX_KNOTS);
    assign w_accept = start && !busy;
    assign busy = (r_state != S_IDLE);

    // binary search step
    always_comb begin
        w_nlo   = r_lo;
        w_nhi   = r_hi;
        w_found = 1'b0;
        priority if (r_lt) w_nhi = r_mid;
        else if (!i_stat.u_lt_k) w_nlo = r_mid;
        else w_found = 1'b1;
        w_lh   = {1'b0, w_nlo} + {1'b0, w_nhi};
        w_nmid = w_lh[KA:1];
    end

    // knot read address for the next state
    always_comb begin
        unique case (r_state)
            S_CHK:   o_kaddr = KA'(32'(r_last) + 1);
            S_END:   o_kaddr = KA'(w_p);
            S_MB:    o_kaddr = r_mid + 1'b1;
            S_JL:    o_kaddr = KA'(32'(r_span) + 1 - 32'(r_j));
            S_JLW:   o_kaddr = KA'(32'(r_span) + 32'(r_j));
            default: o_kaddr = r_mid;
        endcase
    end

    assign o_paddr = PA'(32'(r_span) - 32'(w_p) + 32'(r_r));
    assign o_jidx  = r_j;
    assign o_ridx  = r_r;

    // datapath command
    always_comb begin
        o_cmd.op  = DP_NOP;
        o_cmd.sel = r_sel;
        o_cmd.fin = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_operation)
                        OP_WKNOT: o_cmd.op = DP_WKNOT;
                        OP_WPT:   o_cmd.op = DP_WPT;
                        OP_EVAL:  o_cmd.op = DP_LOAD;
                        default:  o_cmd.op = DP_NOP;
                    endcase
                end
            end
            S_BAS:  o_cmd.op = DP_NB0;
            S_JLW:  o_cmd.op = DP_LFT;
            S_JRW:  o_cmd.op = DP_RGT;
            S_T:    o_cmd.op = DP_TERM;
            S_TD:   o_cmd.op = i_stat.den_zero ? DP_UPD_Z : DP_MUL_A;
            S_DA:   o_cmd.op = DP_DIV_GO;
            S_WA:   o_cmd.op = i_stat.div_done ? DP_SAVE_A : DP_NOP;
            S_MB2:  o_cmd.op = DP_MUL_B;
            S_DB:   o_cmd.op = DP_DIV_GO;
            S_WB:   o_cmd.op = i_stat.div_done ? DP_UPD : DP_NOP;
            S_NBJ:  o_cmd.op = DP_NBJ;
            S_KW:   o_cmd.op = DP_BW_MUL;
            S_BW:   o_cmd.op = DP_BW;
            S_MCO:  o_cmd.op = DP_MC;
            S_ACO:  o_cmd.op = DP_AC;
            S_FD: begin
                o_cmd.op  = DP_DIV_GO;
                o_cmd.fin = 1'b1;
            end
            S_FW:   o_cmd.op = i_stat.div_done ? DP_QOUT : DP_NOP;
            default: ;
        endcase
    end

    // state, counters and registered result outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_degree    <= 3'd3;
            r_last      <= 5'd3;
            r_res_valid <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DEGREE: r_degree <= i_cfg_data[2:0];
                    CFG_LAST:   r_last   <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_operation == OP_EVAL) r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_bad) begin
                        r_res_valid <= 1'b1;
                        r_status    <= ST_RANGE;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (i_stat.u_eq_k) begin
                        r_span  <= KA'(r_last);
                        r_state <= S_BAS;
                    end else begin
                        r_gtend <= !i_stat.u_lt_k;
                        r_state <= S_LOW;
                    end
                end
                S_LOW: begin
                    if (i_stat.u_lt_k || r_gtend) begin
                        r_res_valid <= 1'b1;
                        r_status    <= ST_RANGE;
                        r_state     <= S_IDLE;
                    end else begin
                        r_lo    <= KA'(w_p);
                        r_hi    <= KA'(32'(r_last) + 1);
                        r_mid   <= KA'((32'(w_p) + 32'(r_last) + 1) >> 1);
                        r_iter  <= '0;
                        r_state <= S_MA;
                    end
                end
                S_MA: r_state <= S_MB;
                S_MB: begin
                    r_lt    <= i_stat.u_lt_k;
                    r_state <= S_MC;
                end
                S_MC: begin
                    r_lo   <= w_nlo;
                    r_hi   <= w_nhi;
                    r_mid  <= w_nmid;
                    r_iter <= r_iter + 1'b1;
                    if (w_found) begin
                        r_span  <= r_mid;
                        r_state <= S_BAS;
                    end else if (r_iter == IW'(MAX_KNOTS - 1)) begin
                        r_res_valid <= 1'b1;
                        r_status    <= ST_RANGE;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_MA;
                    end
                end
                S_BAS: begin
                    r_j <= DW'(1);
                    r_r <= '0;
                    r_state <= (w_p == '0) ? S_KR : S_JL;
                end
                S_JL:  r_state <= S_JLW;
                S_JLW: r_state <= S_JRW;
                S_JRW: begin
                    r_r     <= '0;
                    r_state <= S_T;
                end
                S_T:  r_state <= S_TD;
                S_TD: begin
                    if (i_stat.den_zero) begin
                        if (r_r == r_j - 1'b1) r_state <= S_NBJ;
                        else begin
                            r_r     <= r_r + 1'b1;
                            r_state <= S_T;
                        end
                    end else begin
                        r_state <= S_DA;
                    end
                end
                S_DA: r_state <= S_WA;
                S_WA: if (i_stat.div_done) r_state <= S_MB2;
                S_MB2: r_state <= S_DB;
                S_DB: r_state <= S_WB;
                S_WB: begin
                    if (i_stat.div_done) begin
                        if (r_r == r_j - 1'b1) r_state <= S_NBJ;
                        else begin
                            r_r     <= r_r + 1'b1;
                            r_state <= S_T;
                        end
                    end
                end
                S_NBJ: begin
                    if (r_j == w_p) begin
                        r_r     <= '0;
                        r_state <= S_KR;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_JL;
                    end
                end
                S_KR: r_state <= S_KW;
                S_KW: r_state <= S_BW;
                S_BW: begin
                    r_sel   <= 2'd0;
                    r_state <= S_MCO;
                end
                S_MCO: r_state <= S_ACO;
                S_ACO: begin
                    if (r_sel == 2'd2) begin
                        if (r_r == w_p) r_state <= S_FIN;
                        else begin
                            r_r     <= r_r + 1'b1;
                            r_state <= S_KR;
                        end
                    end else begin
                        r_sel   <= r_sel + 1'b1;
                        r_state <= S_MCO;
                    end
                end
                S_FIN: begin
                    if (i_stat.sw_zero) begin
                        r_res_valid <= 1'b1;
                        r_status    <= ST_WZERO;
                        r_state     <= S_IDLE;
                    end else begin
                        r_sel   <= 2'd0;
                        r_state <= S_FD;
                    end
                end
                S_FD: r_state <= S_FW;
                S_FW: begin
                    if (i_stat.div_done) begin
                        if (r_sel == 2'd2) begin
                            r_res_valid <= 1'b1;
                            r_status    <= ST_OK;
                            r_state     <= S_IDLE;
                        end else begin
                            r_sel   <= r_sel + 1'b1;
                            r_state <= S_FD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_status       = r_status;

endmodule

/* sv/nurbs_curve_point_eval_core.sv */
// ============================================================================
// nurbs_curve_point_eval_core
// Rational B-spline curve point evaluator: knot and control point stores,
// knot span search, Cox-de Boor basis, weighted sums and final division.
// ============================================================================
//
// channel   signals                                   direction  handshake
// request   start/busy, i_operation .. i_param_u      in         start & !busy
// result    o_result_valid, o_curve_x/y/z, o_status   out        strobe, 1 cycle
// config    i_cfg_valid/o_cfg_ready, index, data      in         valid & ready
//
// Write requests raise no busy.
// An evaluate runs a binary span search (S_MA, S_MB, S_MC per step) unless u
// is the end knot, then per recurrence term, p*(p+1)/2 terms, two passes of
// the shared divider (64 quotient steps each) unless the term's denominator
// is zero, one multiply-accumulate pass per control point and three final
// divisions unless the weight sum is zero. The divider passes dominate the time.
// Reset is synchronous: degree and last index go to 3; stores are not cleared.
// The result strobe cannot be stalled; busy drops with it.
module nurbs_curve_point_eval_core
    import ncpe_pkg::*;
#(
    parameter int MAX_DEGREE      = 7,
    parameter int MAX_CTRL_POINTS = 32,
    parameter int MAX_KNOTS       = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_operation,
    input  logic [5:0]                i_index,
    input  logic [KNOT_W-1:0]         i_knot_value,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    input  logic signed [COORD_W-1:0] i_point_z,
    input  logic [WGT_W-1:0]          i_point_weight,
    input  logic [KNOT_W-1:0]         i_param_u,
    output logic                      o_result_valid,
    output logic signed [COORD_W-1:0] o_curve_x,
    output logic signed [COORD_W-1:0] o_curve_y,
    output logic signed [COORD_W-1:0] o_curve_z,
    output logic [1:0]                o_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [4:0]                i_cfg_data
);

    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int KA = $clog2(MAX_KNOTS);
    localparam int PA = $clog2(MAX_CTRL_POINTS);

    t_dp_cmd       w_cmd;
    t_dp_stat      w_stat;
    logic [DW-1:0] w_jidx, w_ridx;
    logic [KA-1:0] w_kaddr;
    logic [PA-1:0] w_paddr;

    // configuration writes always taken
    assign o_cfg_ready = 1'b1;

    ncpe_ctrl #(
        .MAX_DEGREE      (MAX_DEGREE),
        .MAX_CTRL_POINTS (MAX_CTRL_POINTS),
        .MAX_KNOTS       (MAX_KNOTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_cmd          (w_cmd),
        .o_jidx         (w_jidx),
        .o_ridx         (w_ridx),
        .o_kaddr        (w_kaddr),
        .o_paddr        (w_paddr),
        .i_stat         (w_stat),
        .o_result_valid (o_result_valid),
        .o_status       (o_status)
    );

    ncpe_dp #(
        .MAX_DEGREE      (MAX_DEGREE),
        .MAX_CTRL_POINTS (MAX_CTRL_POINTS),
        .MAX_KNOTS       (MAX_KNOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_jidx         (w_jidx),
        .i_ridx         (w_ridx),
        .i_kaddr        (w_kaddr),
        .i_paddr        (w_paddr),
        .i_index        (i_index),
        .i_knot_value   (i_knot_value),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_point_weight (i_point_weight),
        .i_param_u      (i_param_u),
        .o_stat         (w_stat),
        .o_curve_x      (o_curve_x),
        .o_curve_y      (o_curve_y),
        .o_curve_z      (o_curve_z)
    );

`ifndef SYNTHESIS
    // a result ends an evaluation that was in progress
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without evaluation");

    // failed evaluations report a zero point
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_OK) |->
            (o_curve_x == '0 && o_curve_y == '0 && o_curve_z == '0))
        else $error("nonzero point on failed evaluation");

    // one result per evaluation
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");
`endif

endmodule
